// File: rtl/pbb_pkg.sv
// shared constants, types and helpers for the page bitmap blit core
package pbb_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 32;
    localparam int DISP_PAGES     = DISPLAY_HEIGHT / 8;
    localparam int FB_DEPTH       = 512;
    localparam int FB_AW          = $clog2(FB_DEPTH);
    localparam int ADDR_CALC_W    = 18;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;
    localparam int CFG_IDX_W = 3;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [1:0] FUNC_BLIT  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_PAGES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_HEIGHT = 3'd4;

    typedef struct packed {
        logic [FB_AW-1:0] addr;
        logic [7:0]       bits;
        logic [7:0]       mask;
    } op_t;

    typedef struct packed {
        logic kind;
        logic two;
        op_t  op0;
        op_t  op1;
    } cmd_t;

    // row mask of the last source page, pixel count clamped to 1..8
    function automatic logic [7:0] last_page_mask(input logic [7:0] height,
                                                  input logic [7:0] pages);
        logic signed [11:0] px;
        logic [7:0]         pm1;
        logic [7:0]         m;
        pm1 = pages - 8'd1;
        px  = $signed({4'b0000, height}) - $signed({1'b0, pm1, 3'b000});
        if (px < 12'sd1) begin
            m = 8'h01;
        end else if (px > 12'sd8) begin
            m = 8'hFF;
        end else begin
            m = 8'hFF >> (4'd8 - px[3:0]);
        end
        return m;
    endfunction

endpackage

// File: rtl/page_bitmap_blit_core.sv
// top level of the page bitmap blit core
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    tdata, tuser
//  m_        out        m_tvalid / m_tready    tdata, tuser, tlast
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// the front takes one transaction per cycle while the two-entry queue has room
// the back end retires one framebuffer access per cycle while the m_ side is not stalled:
// a read or write is one access, a blit byte one access per destination page touched (one or two)
// an input transaction passes through the queue, the read stage and the output
// register before m_tvalid rises
// after reset a clearing pass zeroes all 512 framebuffer bytes, s_tready is low
// a stalled m_ side holds results in the output register and backs up the queue
module page_bitmap_blit_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] data_byte, [16:8] fb_addr, [23:17] zero
    input  logic [pbb_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func, [2] first_byte
    input  logic [pbb_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [8:0] out_addr, [16:9] out_data, [23:17] zero
    output logic [pbb_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] kind
    output logic [pbb_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import pbb_pkg::*;

    logic q_full, q_push, q_pop, q_head_valid, clr_busy;
    cmd_t q_push_cmd, q_head_cmd;

    assign cfg_ready = 1'b1;

    pbb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .clr_busy  (clr_busy),
        .push      (q_push),
        .push_cmd  (q_push_cmd)
    );

    pbb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    pbb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .clr_busy   (clr_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// File: rtl/pbb_queue.sv
// command queue between the classifying front and the memory back end
module pbb_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pbb_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output pbb_pkg::cmd_t head_cmd
);
    import pbb_pkg::*;

    cmd_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;

    assign full       = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/pbb_front.sv
// front end: config registers, blit counters and command classification
module pbb_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [pbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pbb_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [pbb_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                            q_full,
    input  logic                            clr_busy,
    output logic                            push,
    output pbb_pkg::cmd_t                   push_cmd
);
    import pbb_pkg::*;

    logic [7:0] origin_x_reg, origin_y_reg, width_reg, pages_reg, height_reg;
    logic [7:0] col_reg, col_next;
    logic [7:0] pg_reg, pg_next;

    logic [1:0]       func;
    logic             first;
    logic [7:0]       data;
    logic [FB_AW-1:0] fb_addr;
    logic             accept;

    logic [7:0]  col_eff, pg_eff;
    logic        active;
    logic [8:0]  col_inc;
    logic        origin_on, col_in;
    logic [8:0]  col_abs;
    logic [7:0]  mask;
    logic [2:0]  yoff;
    logic [8:0]  page0;
    logic [9:0]  page1;
    logic [ADDR_CALC_W-1:0] addr0, addr1;
    logic        op0_ok, op1_ok;
    logic [15:0] bits_w, mask_w;
    logic        draw;

    assign func    = s_tuser[1:0];
    assign first   = s_tuser[2];
    assign data    = s_tdata[7:0];
    assign fb_addr = s_tdata[8 +: FB_AW];

    assign s_tready = !q_full && !clr_busy;
    assign accept   = s_tvalid && s_tready;

    assign col_eff = first ? 8'd0 : col_reg;
    assign pg_eff  = first ? 8'd0 : pg_reg;
    assign active  = (width_reg != 8'd0) && (pages_reg != 8'd0) && (pg_eff < pages_reg);
    assign col_inc = {1'b0, col_eff} + 9'd1;

    always_comb begin
        col_next = col_eff;
        pg_next  = pg_eff;
        if (active) begin
            if (col_inc >= {1'b0, width_reg}) begin
                col_next = 8'd0;
                pg_next  = pg_eff + 8'd1;
            end else begin
                col_next = col_inc[7:0];
            end
        end
    end

    assign origin_on = ({1'b0, origin_x_reg} < 9'(DISPLAY_WIDTH))
                    && ({1'b0, origin_y_reg} < 9'(DISPLAY_HEIGHT));
    assign col_abs   = {1'b0, origin_x_reg} + {1'b0, col_eff};
    assign col_in    = (col_eff < width_reg) && (col_abs < 9'(DISPLAY_WIDTH));

    assign mask = ((({1'b0, pg_eff} + 9'd1) == {1'b0, pages_reg}) && (height_reg != 8'd0))
                ? last_page_mask(height_reg, pages_reg) : 8'hFF;

    assign yoff  = origin_y_reg[2:0];
    assign page0 = {4'b0000, origin_y_reg[7:3]} + {1'b0, pg_eff};
    assign page1 = {1'b0, page0} + 10'd1;
    assign addr0 = ADDR_CALC_W'(page0) * ADDR_CALC_W'(DISPLAY_WIDTH) + ADDR_CALC_W'(col_abs);
    assign addr1 = ADDR_CALC_W'(page1) * ADDR_CALC_W'(DISPLAY_WIDTH) + ADDR_CALC_W'(col_abs);
    assign op0_ok = (page0 < 9'(DISP_PAGES)) && (addr0 < ADDR_CALC_W'(FB_DEPTH));
    assign op1_ok = (yoff != 3'd0) && (page1 < 10'(DISP_PAGES))
                 && (addr1 < ADDR_CALC_W'(FB_DEPTH));

    assign bits_w = {8'h00, data} << yoff;
    assign mask_w = {8'h00, mask} << yoff;
    assign draw   = active && origin_on && col_in && op0_ok;

    always_comb begin
        push_cmd = '0;
        push     = 1'b0;
        unique case (func)
            FUNC_BLIT: begin
                push               = accept && draw;
                push_cmd.kind      = KIND_WRITE;
                push_cmd.two       = op1_ok;
                push_cmd.op0.addr  = addr0[FB_AW-1:0];
                push_cmd.op0.bits  = bits_w[7:0];
                push_cmd.op0.mask  = mask_w[7:0];
                push_cmd.op1.addr  = addr1[FB_AW-1:0];
                push_cmd.op1.bits  = bits_w[15:8];
                push_cmd.op1.mask  = mask_w[15:8];
            end
            FUNC_READ: begin
                push              = accept;
                push_cmd.kind     = KIND_READ;
                push_cmd.op0.addr = fb_addr;
            end
            FUNC_WRITE: begin
                push              = accept;
                push_cmd.kind     = KIND_WRITE;
                push_cmd.op0.addr = fb_addr;
                push_cmd.op0.bits = data;
                push_cmd.op0.mask = 8'hFF;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            width_reg    <= '0;
            pages_reg    <= '0;
            height_reg   <= '0;
            col_reg      <= '0;
            pg_reg       <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_ORIGIN_X:     origin_x_reg <= cfg_data;
                    CFG_ORIGIN_Y:     origin_y_reg <= cfg_data;
                    CFG_SLICE_WIDTH:  width_reg    <= cfg_data;
                    CFG_SLICE_PAGES:  pages_reg    <= cfg_data;
                    CFG_SLICE_HEIGHT: height_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (accept && (func == FUNC_BLIT)) begin
                col_reg <= col_next;
                pg_reg  <= pg_next;
            end
        end
    end

endmodule

// File: rtl/pbb_back.sv
// back end: framebuffer memory, read-modify-write pipeline and output register
module pbb_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  pbb_pkg::cmd_t                 head_cmd,
    output logic                          pop,
    output logic                          clr_busy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pbb_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [pbb_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import pbb_pkg::*;

    logic [7:0]       fb_mem [FB_DEPTH];
    logic [7:0]       rd_reg;

    logic             clr_busy_reg;
    logic [FB_AW-1:0] clr_addr_reg;

    logic             sub_reg, sub_next;

    logic             s2_valid_reg;
    logic [FB_AW-1:0] s2_addr_reg;
    logic [7:0]       s2_bits_reg, s2_mask_reg;
    logic             s2_kind_reg, s2_last_reg;
    logic             s2_fwd_reg;
    logic [7:0]       s2_fwd_data_reg;

    logic             out_valid_reg;
    logic             out_kind_reg, out_last_reg;
    logic [FB_AW-1:0] out_addr_reg;
    logic [7:0]       out_data_reg;

    logic             s2_go, s2_free, issue, last_sel;
    op_t              op_sel;
    logic [7:0]       old_val, new_val;

    assign clr_busy = clr_busy_reg;

    assign s2_go    = s2_valid_reg && (!out_valid_reg || m_tready);
    assign s2_free  = !s2_valid_reg || s2_go;
    assign issue    = !clr_busy_reg && head_valid && s2_free;
    assign op_sel   = sub_reg ? head_cmd.op1 : head_cmd.op0;
    assign last_sel = sub_reg || !head_cmd.two;
    assign pop      = issue && last_sel;
    assign sub_next = issue ? !last_sel : sub_reg;

    assign old_val = s2_fwd_reg ? s2_fwd_data_reg : rd_reg;
    assign new_val = (old_val & ~s2_mask_reg) | (s2_bits_reg & s2_mask_reg);

    // clearing pass, then one write per retiring access
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            fb_mem[clr_addr_reg] <= 8'h00;
        end else if (s2_go) begin
            fb_mem[s2_addr_reg] <= new_val;
        end
        if (issue) begin
            rd_reg <= fb_mem[op_sel.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            sub_reg       <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == FB_AW'(FB_DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            sub_reg <= sub_next;
            if (issue) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_go) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s2_addr_reg     <= op_sel.addr;
            s2_bits_reg     <= op_sel.bits;
            s2_mask_reg     <= op_sel.mask;
            s2_kind_reg     <= head_cmd.kind;
            s2_last_reg     <= last_sel;
            // write of the retiring access lands in the same cycle as this read
            s2_fwd_reg      <= s2_go && (s2_addr_reg == op_sel.addr);
            s2_fwd_data_reg <= new_val;
        end
        if (s2_go) begin
            out_kind_reg <= s2_kind_reg;
            out_addr_reg <= s2_addr_reg;
            out_data_reg <= new_val;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - FB_AW - 8)'(0), out_data_reg, out_addr_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/pbb_checker.sv
// port-level checker for the page bitmap blit core, bound to the top level
module pbb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pbb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [pbb_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);
    import pbb_pkg::*;

    // no result right after reset
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // clearing pass blocks input after reset
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input accepted during clearing pass");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a read returns exactly one result, so it is always the final one
    a_read_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == KIND_READ) |-> m_tlast)
        else $error("read result without tlast");

endmodule

bind page_bitmap_blit_core pbb_checker u_pbb_checker (.*);

// File: sim/pbb_blit_checker.sv
// checker for the page bitmap blit core: framebuffer predictor and result comparison
module pbb_blit_checker
    import pbb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 m_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output int                   fail_count,
    output int                   results_due
);

    typedef struct packed {
        logic             kind;
        logic [FB_AW-1:0] addr;
        logic [7:0]       data;
        logic             last;
    } fb_access_t;

    logic [7:0] fb_shadow [FB_DEPTH];
    logic [7:0] reg_origin_x, reg_origin_y, reg_slice_width, reg_slice_pages, reg_slice_height;
    int         col_pos, page_pos, mismatches, i;
    fb_access_t access_q [$];
    fb_access_t want, got;

    function automatic int merge_byte(int page, int column, int bits, int mask);
        int         addr;
        fb_access_t acc;
        addr = page * DISPLAY_WIDTH + column;
        if (page >= DISP_PAGES || addr >= FB_DEPTH) begin
            return 0;
        end
        fb_shadow[addr] = (fb_shadow[addr] & ~8'(mask)) | (8'(bits) & 8'(mask));
        acc.kind = KIND_WRITE;
        acc.addr = addr[FB_AW-1:0];
        acc.data = fb_shadow[addr];
        acc.last = 1'b0;
        access_q.push_back(acc);
        return 1;
    endfunction

    function automatic void place_source_byte(logic [7:0] data);
        int         ox, oy, span, px, mask, yoff, top_page, made, dv;
        fb_access_t tail;
        ox   = int'(reg_origin_x);
        oy   = int'(reg_origin_y);
        dv   = int'(data);
        made = 0;
        if (ox < DISPLAY_WIDTH && oy < DISPLAY_HEIGHT) begin
            span = int'(reg_slice_width);
            if (ox + span > DISPLAY_WIDTH) begin
                span = DISPLAY_WIDTH - ox;
            end
            if (col_pos < span) begin
                mask = 255;
                if (page_pos + 1 == int'(reg_slice_pages) && reg_slice_height != 8'd0) begin
                    px = int'(reg_slice_height) - 8 * (int'(reg_slice_pages) - 1);
                    if (px < 1) begin
                        px = 1;
                    end
                    if (px > 8) begin
                        px = 8;
                    end
                    mask = (1 << px) - 1;
                end
                yoff     = oy % 8;
                top_page = oy / 8;
                made += merge_byte(top_page + page_pos, ox + col_pos,
                                   (dv << yoff) & 255, (mask << yoff) & 255);
                if (yoff != 0) begin
                    made += merge_byte(top_page + page_pos + 1, ox + col_pos,
                                       dv >> (8 - yoff), mask >> (8 - yoff));
                end
                if (made > 0) begin
                    tail      = access_q.pop_back();
                    tail.last = 1'b1;
                    access_q.push_back(tail);
                end
            end
        end
        col_pos++;
        if (col_pos >= int'(reg_slice_width)) begin
            col_pos = 0;
            page_pos++;
        end
    endfunction

    function automatic void take_item(logic [1:0] func, logic [7:0] data, logic first,
                                      logic [FB_AW-1:0] addr);
        fb_access_t acc;
        acc.addr = addr;
        acc.last = 1'b1;
        case (func)
            FUNC_BLIT: begin
                if (first) begin
                    col_pos  = 0;
                    page_pos = 0;
                end
                if (reg_slice_width != 8'd0 && reg_slice_pages != 8'd0 &&
                    page_pos < int'(reg_slice_pages)) begin
                    place_source_byte(data);
                end
            end
            FUNC_READ: begin
                acc.kind = KIND_READ;
                acc.data = fb_shadow[addr];
                access_q.push_back(acc);
            end
            FUNC_WRITE: begin
                fb_shadow[addr] = data;
                acc.kind = KIND_WRITE;
                acc.data = data;
                access_q.push_back(acc);
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (i = 0; i < FB_DEPTH; i++) begin
                fb_shadow[i] = 8'd0;
            end
            reg_origin_x     = 8'd0;
            reg_origin_y     = 8'd0;
            reg_slice_width  = 8'd0;
            reg_slice_pages  = 8'd0;
            reg_slice_height = 8'd0;
            col_pos          = 0;
            page_pos         = 0;
            access_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ORIGIN_X:     reg_origin_x     = cfg_data;
                    CFG_ORIGIN_Y:     reg_origin_y     = cfg_data;
                    CFG_SLICE_WIDTH:  reg_slice_width  = cfg_data;
                    CFG_SLICE_PAGES:  reg_slice_pages  = cfg_data;
                    CFG_SLICE_HEIGHT: reg_slice_height = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser[0];
                got.addr = m_tdata[FB_AW-1:0];
                got.data = m_tdata[FB_AW+7:FB_AW];
                got.last = m_tlast;
                if (access_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected result kind %0d addr %0d data %02h last %0d",
                                 $realtime, got.kind, got.addr, got.data, got.last);
                    end
                    mismatches++;
                end else begin
                    want = access_q.pop_front();
                    if (got.kind !== want.kind || got.addr !== want.addr ||
                        got.data !== want.data || got.last !== want.last) begin
                        if (mismatches < 10) begin
                            $display({"%0t: result mismatch expected kind %0d addr %0d ",
                                      "data %02h last %0d, got kind %0d addr %0d ",
                                      "data %02h last %0d"},
                                     $realtime, want.kind, want.addr, want.data, want.last,
                                     got.kind, got.addr, got.data, got.last);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                take_item(s_tuser[1:0], s_tdata[7:0], s_tuser[2], s_tdata[FB_AW+7:8]);
            end
        end
        fail_count  <= mismatches;
        results_due <= access_q.size();
    end

endmodule

// File: sim/tb_page_bitmap_blit_core.sv
// testbench top for the page bitmap blit core: stimulus, idling phases and verdict
module tb_page_bitmap_blit_core;
    import pbb_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int ITEM_TARGET   = 1650;
    localparam int SETTLE_CYCLES = 16;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 cfg_ready;

    int fail_count;
    int results_due;
    int items_sent    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int phase;

    page_bitmap_blit_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pbb_blit_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] func, logic [7:0] data, logic first,
                             logic [FB_AW-1:0] addr);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, addr, data};
        s_tuser  <= {first, func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // hold the sender until every expected transaction has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic load_slice(logic [7:0] ox, logic [7:0] oy, logic [7:0] w,
                              logic [7:0] p, logic [7:0] h);
        settle();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_SLICE_WIDTH, w);
        write_reg(CFG_SLICE_PAGES, p);
        write_reg(CFG_SLICE_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_misc();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5) begin
            send_item(FUNC_READ, 8'($urandom), 1'($urandom), FB_AW'($urandom));
        end else if (pick < 9) begin
            send_item(FUNC_WRITE, 8'($urandom), 1'($urandom), FB_AW'($urandom));
        end else begin
            send_item(FUNC_NONE, 8'($urandom), 1'($urandom), FB_AW'($urandom));
        end
    endtask

    task automatic blit_job(int nbytes, int mix_pct, bit with_first);
        int k;
        for (k = 0; k < nbytes; k++) begin
            if ($urandom_range(99) < mix_pct) begin
                send_misc();
            end
            send_item(FUNC_BLIT, 8'($urandom), with_first && k == 0, FB_AW'($urandom));
        end
    endtask

    task automatic random_job();
        logic [7:0] ox, oy, w, p, h;
        int         r, full, cap, style, k;
        r  = $urandom_range(19);
        ox = (r < 14) ? 8'($urandom_range(0, 127)) : (r < 18) ? 8'($urandom_range(110, 160)) :
             (r == 18) ? 8'd255 : 8'($urandom_range(0, 255));
        r  = $urandom_range(19);
        oy = (r < 14) ? 8'($urandom_range(0, 31)) : (r < 18) ? 8'($urandom_range(20, 40)) :
             (r == 18) ? 8'd255 : 8'($urandom_range(0, 255));
        r  = $urandom_range(19);
        w  = (r < 15) ? 8'($urandom_range(1, 12)) : (r == 15) ? 8'd0 :
             (r == 16) ? 8'd255 : 8'($urandom_range(1, 140));
        r  = $urandom_range(19);
        p  = (r < 16) ? 8'($urandom_range(1, 5)) : (r == 16) ? 8'd0 :
             (r == 17) ? 8'd255 : 8'($urandom_range(1, 3));
        r  = $urandom_range(19);
        h  = (r < 6) ? 8'd0 : (r < 16) ? 8'($urandom_range(0, 8 * int'(p) + 8 > 255 ?
             255 : 8 * int'(p) + 8)) : (r == 16) ? 8'd255 : 8'($urandom_range(0, 255));
        load_slice(ox, oy, w, p, h);
        full = int'(w) * int'(p);
        cap  = ($urandom_range(3) == 0) ? 300 : 64;
        if (full > cap) begin
            full = cap;
        end
        if (full == 0) begin
            full = 3;
        end
        style = $urandom_range(9);
        if (style < 7) begin
            blit_job(full, 10, 1'b1);
            if ($urandom_range(9) < 3) begin
                blit_job($urandom_range(1, 3), 0, 1'b0);
            end
        end else if (style == 7) begin
            for (k = 0; k < 20; k++) begin
                send_item(2'($urandom), 8'($urandom), 1'($urandom), FB_AW'($urandom));
            end
        end else if (style == 8) begin
            blit_job(full / 2 + 1, 10, 1'b1);
            blit_job(full, 10, 1'b1);
        end else begin
            blit_job(full, 10, 1'b0);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // drawing disabled after reset, then direct framebuffer access
        send_item(FUNC_BLIT, 8'hFF, 1'b1, 9'd0);
        send_item(FUNC_WRITE, 8'hFF, 1'b0, 9'd0);
        send_item(FUNC_WRITE, 8'hA5, 1'b1, 9'h1FF);
        send_item(FUNC_READ, 8'h00, 1'b0, 9'd0);
        send_item(FUNC_READ, 8'hFF, 1'b1, 9'h1FF);
        send_item(FUNC_NONE, 8'h5A, 1'b1, 9'h0AA);
        // widest and tallest slice, aligned
        load_slice(8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        send_item(FUNC_BLIT, 8'hFF, 1'b1, 9'h1FF);
        send_item(FUNC_BLIT, 8'h00, 1'b0, 9'd0);
        // unaligned, clipped on the right, masked last page, bytes past job end
        load_slice(8'd126, 8'd5, 8'd4, 8'd2, 8'd11);
        blit_job(9, 0, 1'b1);
        // bottom page clipped, last page height clamped low
        load_slice(8'd0, 8'd24, 8'd2, 8'd2, 8'd1);
        blit_job(4, 0, 1'b1);
        // origin off screen
        load_slice(8'd255, 8'd255, 8'd3, 8'd1, 8'd0);
        blit_job(2, 0, 1'b1);
        load_slice(8'd8, 8'd0, 8'd0, 8'd3, 8'd0);
        blit_job(1, 0, 1'b1);
        load_slice(8'd8, 8'd0, 8'd3, 8'd0, 8'd0);
        blit_job(1, 0, 1'b1);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct <= 0;  recv_idle_pct <= 0;  end
                1: begin send_idle_pct <= 74; recv_idle_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_idle_pct <= 74; end
                default: begin send_idle_pct <= 8; recv_idle_pct <= 8; end
            endcase
            while (items_sent < 25 + (phase + 1) * ITEM_TARGET / 4) begin
                random_job();
            end
        end

        settle();
        if (fail_count == 0 && results_due == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/pbb_pkg.sv
rtl/pbb_queue.sv
rtl/pbb_front.sv
rtl/pbb_back.sv
rtl/page_bitmap_blit_core.sv
rtl/pbb_checker.sv
sim/pbb_blit_checker.sv
sim/tb_page_bitmap_blit_core.sv
